// ===== rtl/core/bve_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and helpers for the ber value encoder
// no dependencies

package bve_pkg;

    typedef logic [7:0] t_byte;

    // input operation codes
    localparam logic [1:0] OP_SIGNED   = 2'd0;
    localparam logic [1:0] OP_UNSIGNED = 2'd1;
    localparam logic [1:0] OP_SUBID    = 2'd2;

    // status codes on the result side
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_MANY = 2'd1;
    localparam logic [1:0] ST_TOO_FEW  = 2'd2;

    // tag bytes
    localparam t_byte TAG_INTEGER = 8'h02;
    localparam t_byte TAG_OID     = 8'h06;

    // width of the oid content length
    localparam int LEN_W = 7;

    // up to seven bytes, first byte in the top octet, plus how many are used
    typedef struct packed {
        logic [55:0] bytes;
        logic [2:0]  count;
    } t_frame;

    // number of base-128 groups for one subid
    function automatic logic [2:0] group_count(input logic [31:0] v);
        logic [2:0] g;
        if (v >= 32'h1000_0000)      g = 3'd5;
        else if (v >= 32'h0020_0000) g = 3'd4;
        else if (v >= 32'h0000_4000) g = 3'd3;
        else if (v >= 32'h0000_0080) g = 3'd2;
        else                         g = 3'd1;
        return g;
    endfunction

endpackage

// ===== rtl/core/bve_subid_ram.sv =====
`timescale 1ns / 1ps
// subid store: one write port, one read port with registered read data
// depends on nothing

module bve_subid_ram #(
    parameter int DEPTH = 14,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/bve_scalar_fmt.sv =====
`timescale 1ns / 1ps
// builds the tlv byte frame of a signed or unsigned scalar item
// depends on bve_pkg

module bve_scalar_fmt (
    input  logic            i_signed_mode,
    input  logic [31:0]     i_data_word,
    input  logic [7:0]      i_tag_code,
    output bve_pkg::t_frame o_frame
);

    logic [2:0]  len_v;
    logic        top_bit;
    logic        pad;
    logic [2:0]  content_cnt;
    logic [39:0] content;
    logic [39:0] body;
    bve_pkg::t_byte tag_sel;

    always_comb begin
        // shortest form: signed drops redundant sign bytes, unsigned drops zero bytes
        if (i_signed_mode) begin
            if ((&i_data_word[31:7]) || !(|i_data_word[31:7]))        len_v = 3'd1;
            else if ((&i_data_word[31:15]) || !(|i_data_word[31:15])) len_v = 3'd2;
            else if ((&i_data_word[31:23]) || !(|i_data_word[31:23])) len_v = 3'd3;
            else                                                     len_v = 3'd4;
        end else begin
            if (|i_data_word[31:24])      len_v = 3'd4;
            else if (|i_data_word[23:16]) len_v = 3'd3;
            else if (|i_data_word[15:8])  len_v = 3'd2;
            else                          len_v = 3'd1;
        end

        case (len_v)
            3'd1:    top_bit = i_data_word[7];
            3'd2:    top_bit = i_data_word[15];
            3'd3:    top_bit = i_data_word[23];
            default: top_bit = i_data_word[31];
        endcase

        // unsigned value with its top bit set gets a leading zero byte
        pad         = !i_signed_mode && top_bit;
        content_cnt = len_v + {2'b00, pad};
        content     = {8'h00, i_data_word};

        case (content_cnt)
            3'd1:    body = content << 32;
            3'd2:    body = content << 24;
            3'd3:    body = content << 16;
            3'd4:    body = content << 8;
            default: body = content;
        endcase

        tag_sel = i_signed_mode ? bve_pkg::TAG_INTEGER : i_tag_code;

        o_frame.bytes = {tag_sel, 5'b00000, content_cnt, body};
        o_frame.count = content_cnt + 3'd2;
    end

endmodule

// ===== rtl/core/ber_value_encoder_core.sv =====
`timescale 1ns / 1ps
// top level of the ber value encoder: control sequencer and output register
// depends on bve_pkg, bve_scalar_fmt, bve_subid_ram

// An item is taken when i_start is high and o_busy is low. Signed and unsigned
// items give a tag, a length and 1 to 5 content bytes; o_busy stays high while
// their bytes go to the output register. Subid items are written into the subid
// memory while it has room; all but the last give no byte, o_busy stays low and
// the next item can follow in the next cycle. The subid marked last starts the
// oid output: three header bytes (tag, length, first byte), then for each further
// subid a memory read, a size step and one byte per base-128 group. Too many or
// too few subids give one byte with a nonzero status. Results come out one per
// cycle on o_valid, save across the read and size steps of each subid; the
// receiver cannot hold them off, and every byte shows for exactly one cycle.
// There is no clearing pass after reset.

module ber_value_encoder_core #(
    parameter int MAX_SUBIDS = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_data_word,
    input  logic [7:0]  i_tag_code,
    input  logic        i_last_subid,
    output logic        o_valid,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte,
    output logic [1:0]  o_status
);

    localparam int CW = $clog2(MAX_SUBIDS + 1);
    localparam int AW = (MAX_SUBIDS > 1) ? $clog2(MAX_SUBIDS) : 1;
    localparam int LW = bve_pkg::LEN_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BUF,
        S_READ,
        S_SIZE,
        S_GROUP
    } t_state;

    t_state r_state, n_state;

    // oid collection state
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [LW-1:0] r_len, n_len;
    logic [7:0]    r_first, n_first;

    // emission state
    logic [55:0]   r_frame, n_frame;
    logic [2:0]    r_left, n_left;
    logic          r_more, n_more;
    logic [1:0]    r_status, n_status;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_end, n_end;
    logic [2:0]    r_grp, n_grp;

    // output register
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_byte, n_out_byte;
    logic          r_out_last, n_out_last;
    logic [1:0]    r_out_status, n_out_status;

    // memory port
    logic          mem_we;
    logic          mem_re;
    logic [31:0]   mem_rdata;

    bve_pkg::t_frame scalar_frame;

    logic          accept;
    logic          full;
    logic [CW-1:0] cnt_now;
    logic          ovf_now;
    logic [7:0]    first_now;
    logic [LW-1:0] len_now;
    logic [LW-1:0] len_byte;
    logic [7:0]    group_byte;
    logic          final_group;

    bve_scalar_fmt u_scalar_fmt (
        .i_signed_mode (i_operation == bve_pkg::OP_SIGNED),
        .i_data_word   (i_data_word),
        .i_tag_code    (i_tag_code),
        .o_frame       (scalar_frame)
    );

    bve_subid_ram #(
        .DEPTH (MAX_SUBIDS),
        .AW    (AW)
    ) u_subid_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_data_word),
        .i_re    (mem_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    assign accept = i_start && (r_state == S_IDLE);

    // effect of storing the incoming subid on the collection state
    always_comb begin
        full      = (r_count == CW'(MAX_SUBIDS));
        cnt_now   = full ? r_count : r_count + CW'(1);
        ovf_now   = r_ovf || full;
        first_now = r_first;
        len_now   = r_len;
        if (!full) begin
            if (r_count == CW'(0)) begin
                // low byte of 40 * first, the rest wraps away
                first_now = {i_data_word[2:0], 5'b00000} + {i_data_word[4:0], 3'b000};
            end else if (r_count == CW'(1)) begin
                first_now = r_first + i_data_word[7:0];
            end else begin
                len_now = r_len + LW'(bve_pkg::group_count(i_data_word));
            end
        end
        len_byte = len_now + LW'(1);
    end

    // one base-128 group of the subid just read, msb group first
    always_comb begin
        case (r_grp)
            3'd5:    group_byte = {1'b1, 3'b000, mem_rdata[31:28]};
            3'd4:    group_byte = {1'b1, mem_rdata[27:21]};
            3'd3:    group_byte = {1'b1, mem_rdata[20:14]};
            3'd2:    group_byte = {1'b1, mem_rdata[13:7]};
            default: group_byte = {1'b0, mem_rdata[6:0]};
        endcase
        final_group = (r_grp == 3'd1) && (r_idx + CW'(1) == r_end);
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ovf        = r_ovf;
        n_len        = r_len;
        n_first      = r_first;
        n_frame      = r_frame;
        n_left       = r_left;
        n_more       = r_more;
        n_status     = r_status;
        n_idx        = r_idx;
        n_end        = r_end;
        n_grp        = r_grp;
        n_out_valid  = 1'b0;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;
        mem_we       = 1'b0;
        mem_re       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_operation)
                        bve_pkg::OP_SIGNED, bve_pkg::OP_UNSIGNED: begin
                            n_frame  = scalar_frame.bytes;
                            n_left   = scalar_frame.count;
                            n_more   = 1'b0;
                            n_status = bve_pkg::ST_OK;
                            n_state  = S_BUF;
                        end
                        bve_pkg::OP_SUBID: begin
                            mem_we  = !full;
                            n_count = cnt_now;
                            n_ovf   = ovf_now;
                            n_first = first_now;
                            n_len   = len_now;
                            if (i_last_subid) begin
                                // oid closes: reset collection, queue the header or an error byte
                                n_count = '0;
                                n_ovf   = 1'b0;
                                n_len   = '0;
                                n_more  = 1'b0;
                                n_state = S_BUF;
                                if (ovf_now) begin
                                    n_frame  = '0;
                                    n_left   = 3'd1;
                                    n_status = bve_pkg::ST_TOO_MANY;
                                end else if (cnt_now < CW'(2)) begin
                                    n_frame  = '0;
                                    n_left   = 3'd1;
                                    n_status = bve_pkg::ST_TOO_FEW;
                                end else begin
                                    n_frame  = {bve_pkg::TAG_OID, 1'b0, len_byte,
                                                first_now, 32'h0};
                                    n_left   = 3'd3;
                                    n_more   = (cnt_now > CW'(2));
                                    n_end    = cnt_now;
                                    n_idx    = CW'(2);
                                    n_status = bve_pkg::ST_OK;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_BUF: begin
                n_out_valid  = 1'b1;
                n_out_byte   = r_frame[55:48];
                n_out_last   = (r_left == 3'd1) && !r_more;
                n_out_status = r_status;
                n_frame      = r_frame << 8;
                n_left       = r_left - 3'd1;
                if (r_left == 3'd1) begin
                    n_state = r_more ? S_READ : S_IDLE;
                end
            end
            S_READ: begin
                mem_re  = 1'b1;
                n_state = S_SIZE;
            end
            S_SIZE: begin
                n_grp   = bve_pkg::group_count(mem_rdata);
                n_state = S_GROUP;
            end
            S_GROUP: begin
                n_out_valid  = 1'b1;
                n_out_byte   = group_byte;
                n_out_last   = final_group;
                n_out_status = bve_pkg::ST_OK;
                n_grp        = r_grp - 3'd1;
                if (r_grp == 3'd1) begin
                    if (final_group) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
        // payload and per-element registers
        r_first      <= n_first;
        r_frame      <= n_frame;
        r_left       <= n_left;
        r_more       <= n_more;
        r_status     <= n_status;
        r_idx        <= n_idx;
        r_end        <= n_end;
        r_grp        <= n_grp;
        r_out_byte   <= n_out_byte;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last_byte = r_out_last;
    assign o_status    = r_out_status;

    // a byte only ever comes out of a busy cycle
    a_valid_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_busy))
        else $error("result strobe without active element");

    // an error result is a lone zero byte that closes the element
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != bve_pkg::ST_OK) |-> (o_last_byte && o_out_byte == 8'h00))
        else $error("error result not a single closing zero byte");

    // subid count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SUBIDS))
        else $error("subid count beyond store depth");

    // a scalar item always starts output
    a_scalar_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_operation == bve_pkg::OP_SIGNED ||
                    i_operation == bve_pkg::OP_UNSIGNED)) |=> o_busy)
        else $error("scalar item did not start output");

    // after the closing byte the block is free again
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_byte) |-> !o_busy)
        else $error("block still busy after closing byte");

endmodule
